### rtl/tsq_pkg.sv
package tsq_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_APPEND = 2'd1;
	localparam logic [1:0] REQ_POP = 2'd2;

	localparam logic [1:0] ERR_OK = 2'd0;
	localparam logic [1:0] ERR_FULL = 2'd1;
	localparam logic [1:0] ERR_EMPTY = 2'd2;

	typedef struct packed {
		logic [23:0] service;
		logic [23:0] arrive;
		logic        cls;
		logic [15:0] id;
	} entry_t;

	typedef struct packed {
		logic ins;
		logic sorted;
		logic pop;
	} cell_ctl_t;

endpackage

### rtl/tsq_cell.sv
module tsq_cell
	import tsq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  entry_t    new_entry,
	input  entry_t    left_entry,
	input  logic      left_valid,
	input  entry_t    right_entry,
	input  logic      right_valid,
	input  logic      found_in,
	output logic      found_out,
	output entry_t    entry,
	output logic      valid
);

	entry_t entry_q;
	logic   valid_q;
	logic   hit;

	// first free cell, or, for a sorted insert, first stored entry arriving later than the new one
	assign hit = ctl.sorted ? (!valid_q || (entry_q.arrive > new_entry.arrive)) : !valid_q;
	assign found_out = found_in | hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.ins) begin
			if (found_in) begin
				valid_q <= left_valid;
			end else if (hit) begin
				valid_q <= 1'b1;
			end
		end else if (ctl.pop) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (found_in) begin
				entry_q <= left_entry;
			end else if (hit) begin
				entry_q <= new_entry;
			end
		end else if (ctl.pop) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;
	assign valid = valid_q;

endmodule

### rtl/timestamp_sorted_queue.sv
// result: the result word for a request is strobed on done in the cycle after start is taken
// throughput: one request per cycle, busy is always low; every cell of the chain
// compares its arrival time and shifts in the same cycle
// reset: asynchronous, all cells empty, count zero; results cannot be stalled
module timestamp_sorted_queue
	import tsq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [15:0] customer_id,
	input  logic        customer_class,
	input  logic [23:0] arrival_ts,
	input  logic [23:0] service_len,
	output logic        done,
	output logic        front_valid,
	output logic [15:0] front_id,
	output logic        front_class,
	output logic [23:0] front_arrive,
	output logic [23:0] front_service,
	output logic [5:0]  entry_count,
	output logic [1:0]  error_code
);

	logic             take;
	logic             full;
	logic             empty;
	logic             is_ins;
	logic             is_pop;
	cell_ctl_t        ctl;
	entry_t           new_entry;
	entry_t           cell_entry [QUEUE_DEPTH];
	logic             cell_valid [QUEUE_DEPTH];
	logic             found      [QUEUE_DEPTH+1];
	logic [CNT_W-1:0] count_q;
	logic [1:0]       err_q;
	logic             done_q;

	assign busy = 1'b0;
	assign take = start && !busy;
	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign is_ins = (req_type == REQ_INSERT) || (req_type == REQ_APPEND);
	assign is_pop = (req_type == REQ_POP);

	assign ctl.ins = take && is_ins && !full;
	assign ctl.sorted = (req_type == REQ_INSERT);
	assign ctl.pop = take && is_pop && !empty;

	assign new_entry.id = customer_id;
	assign new_entry.cls = customer_class;
	assign new_entry.arrive = arrival_ts;
	assign new_entry.service = service_len;

	assign found[0] = 1'b0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t left_e;
		logic   left_v;
		entry_t right_e;
		logic   right_v;

		if (i == 0) begin : g_head
			assign left_e = new_entry;
			assign left_v = 1'b0;
		end else begin : g_mid
			assign left_e = cell_entry[i-1];
			assign left_v = cell_valid[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_e = new_entry;
			assign right_v = 1'b0;
		end else begin : g_body
			assign right_e = cell_entry[i+1];
			assign right_v = cell_valid[i+1];
		end

		tsq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.new_entry   (new_entry),
			.left_entry  (left_e),
			.left_valid  (left_v),
			.right_entry (right_e),
			.right_valid (right_v),
			.found_in    (found[i]),
			.found_out   (found[i+1]),
			.entry       (cell_entry[i]),
			.valid       (cell_valid[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			err_q <= ERR_OK;
			done_q <= 1'b0;
		end else begin
			done_q <= take;
			if (ctl.ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.pop) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (take) begin
				if (is_ins && full) begin
					err_q <= ERR_FULL;
				end else if (is_pop && empty) begin
					err_q <= ERR_EMPTY;
				end else begin
					err_q <= ERR_OK;
				end
			end
		end
	end

	assign done = done_q;
	assign front_valid = cell_valid[0];
	assign front_id = cell_valid[0] ? cell_entry[0].id : '0;
	assign front_class = cell_valid[0] ? cell_entry[0].cls : 1'b0;
	assign front_arrive = cell_valid[0] ? cell_entry[0].arrive : '0;
	assign front_service = cell_valid[0] ? cell_entry[0].service : '0;
	assign entry_count = 6'(count_q);
	assign error_code = err_q;

endmodule

### rtl/tsq_checker.sv
module tsq_checker
	import tsq_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  req_type,
	input logic        done,
	input logic        front_valid,
	input logic [5:0]  entry_count,
	input logic [1:0]  error_code
);

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result word without a request");

	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("request without a result word");

	a_front_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (front_valid == (entry_count != 6'd0)))
		else $error("front valid disagrees with count");

	a_empty_error: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (error_code == ERR_EMPTY)) |-> (entry_count == 6'd0))
		else $error("pop error with entries stored");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req_type == REQ_POP) && done && (entry_count != 6'd0))
		|=> (entry_count == $past(entry_count) - 6'd1))
		else $error("pop did not remove one entry");

endmodule

bind timestamp_sorted_queue tsq_checker u_tsq_checker (.*);

### tb/sv/tsq_checker.sv
`timescale 1ns / 1ps

module tsq_scoreboard
	import tsq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  req_type,
	input  logic [15:0] customer_id,
	input  logic        customer_class,
	input  logic [23:0] arrival_ts,
	input  logic [23:0] service_len,
	input  logic        done,
	input  logic        front_valid,
	input  logic [15:0] front_id,
	input  logic        front_class,
	input  logic [23:0] front_arrive,
	input  logic [23:0] front_service,
	input  logic [5:0]  entry_count,
	input  logic [1:0]  error_code,
	output int          fail_count,
	output int          pending,
	output int          words_checked,
	output int          full_rejects,
	output int          empty_pops,
	output int          peak_fill
);

	typedef struct packed {
		logic        valid;
		logic [15:0] id;
		logic        cls;
		logic [23:0] arrive;
		logic [23:0] service;
		logic [5:0]  count;
		logic [1:0]  err;
	} front_word_t;

	entry_t      slots [QUEUE_DEPTH];
	int          fill;
	front_word_t front_words [$];
	front_word_t predicted;
	front_word_t oldest;
	entry_t      incoming;

	task automatic model_request(input logic [1:0] req, input entry_t e,
		output front_word_t w);
		int pos;
		logic [1:0] err;
		err = ERR_OK;
		if (req == REQ_INSERT || req == REQ_APPEND) begin
			if (fill >= QUEUE_DEPTH) begin
				err = ERR_FULL;
			end else begin
				pos = fill;
				if (req == REQ_INSERT) begin
					for (int k = fill - 1; k >= 0; k--)
						if (slots[k].arrive > e.arrive)
							pos = k;
				end
				for (int k = fill; k > pos; k--)
					slots[k] = slots[k - 1];
				slots[pos] = e;
				fill++;
			end
		end else if (req == REQ_POP) begin
			if (fill == 0) begin
				err = ERR_EMPTY;
			end else begin
				for (int k = 1; k < fill; k++)
					slots[k - 1] = slots[k];
				fill--;
			end
		end
		w = '0;
		if (fill > 0) begin
			w.valid = 1'b1;
			w.id = slots[0].id;
			w.cls = slots[0].cls;
			w.arrive = slots[0].arrive;
			w.service = slots[0].service;
		end
		w.count = fill[5:0];
		w.err = err;
	endtask

	task automatic check_field(input string name, input logic [23:0] exp,
		input logic [23:0] act);
		if (exp !== act) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill = 0;
			front_words.delete();
			pending = 0;
		end else begin
			if (start && !busy) begin
				incoming.id = customer_id;
				incoming.cls = customer_class;
				incoming.arrive = arrival_ts;
				incoming.service = service_len;
				model_request(req_type, incoming, predicted);
				front_words.push_back(predicted);
				if (fill > peak_fill)
					peak_fill = fill;
			end
			if (done) begin
				if (front_words.size() == 0) begin
					$error("result word strobed with no request outstanding");
					fail_count++;
				end else begin
					oldest = front_words.pop_front();
					check_field("front_valid", 24'(oldest.valid), 24'(front_valid));
					check_field("front_id", 24'(oldest.id), 24'(front_id));
					check_field("front_class", 24'(oldest.cls), 24'(front_class));
					check_field("front_arrive", oldest.arrive, front_arrive);
					check_field("front_service", oldest.service, front_service);
					check_field("entry_count", 24'(oldest.count), 24'(entry_count));
					check_field("error_code", 24'(oldest.err), 24'(error_code));
					words_checked++;
					if (oldest.err == ERR_FULL)
						full_rejects++;
					if (oldest.err == ERR_EMPTY)
						empty_pops++;
				end
			end
			pending = front_words.size();
		end
	end

endmodule

### tb/sv/tb_timestamp_sorted_queue.sv
`timescale 1ns / 1ps

module tb_timestamp_sorted_queue;
	import tsq_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 1480;
	localparam int PHASE_LEN = 50;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  req_type = REQ_INSERT;
	logic [15:0] customer_id = '0;
	logic        customer_class = 1'b0;
	logic [23:0] arrival_ts = '0;
	logic [23:0] service_len = '0;
	logic        done;
	logic        front_valid;
	logic [15:0] front_id;
	logic        front_class;
	logic [23:0] front_arrive;
	logic [23:0] front_service;
	logic [5:0]  entry_count;
	logic [1:0]  error_code;

	int fail_count;
	int pending;
	int words_checked;
	int full_rejects;
	int empty_pops;
	int peak_fill;
	int words_sent;

	timestamp_sorted_queue u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.customer_id    (customer_id),
		.customer_class (customer_class),
		.arrival_ts     (arrival_ts),
		.service_len    (service_len),
		.done           (done),
		.front_valid    (front_valid),
		.front_id       (front_id),
		.front_class    (front_class),
		.front_arrive   (front_arrive),
		.front_service  (front_service),
		.entry_count    (entry_count),
		.error_code     (error_code)
	);

	tsq_scoreboard u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.customer_id    (customer_id),
		.customer_class (customer_class),
		.arrival_ts     (arrival_ts),
		.service_len    (service_len),
		.done           (done),
		.front_valid    (front_valid),
		.front_id       (front_id),
		.front_class    (front_class),
		.front_arrive   (front_arrive),
		.front_service  (front_service),
		.entry_count    (entry_count),
		.error_code     (error_code),
		.fail_count     (fail_count),
		.pending        (pending),
		.words_checked  (words_checked),
		.full_rejects   (full_rejects),
		.empty_pops     (empty_pops),
		.peak_fill      (peak_fill)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL timestamp_sorted_queue");
		$finish;
	end

	// one request word, preceded by gap idle cycles
	task automatic issue_request(input logic [1:0] req, input logic [15:0] id,
		input logic cls, input logic [23:0] arr, input logic [23:0] svc, input int gap);
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		req_type = req;
		customer_id = id;
		customer_class = cls;
		arrival_ts = arr;
		service_len = svc;
		do @(posedge clk); while (busy);
		words_sent++;
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		@(negedge clk);
		start = 1'b0;
		while (pending != 0 && guard < 1000) begin
			@(negedge clk);
			guard++;
		end
		repeat (3) @(negedge clk);
	endtask

	initial begin
		int ins_pct;
		logic idle_on;
		int pick;
		logic [1:0] req;
		logic [23:0] arr;

		words_sent = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty pop, ties, extremes, unused code, drain past empty
		issue_request(REQ_POP, 16'h1234, 1'b1, 24'h000001, 24'h000002, 0);
		issue_request(REQ_INSERT, 16'h0001, 1'b0, 24'h000800, 24'h000010, 0);
		issue_request(REQ_INSERT, 16'h0002, 1'b1, 24'h000800, 24'h000020, 1);
		issue_request(REQ_INSERT, 16'h0000, 1'b0, 24'h000000, 24'h000000, 0);
		issue_request(REQ_INSERT, 16'hffff, 1'b1, 24'hffffff, 24'hffffff, 2);
		issue_request(REQ_APPEND, 16'h0003, 1'b0, 24'h000000, 24'h000030, 0);
		issue_request(REQ_INSERT, 16'h0004, 1'b1, 24'h000001, 24'h000040, 0);
		issue_request(REQ_INSERT, 16'h0005, 1'b0, 24'hffffff, 24'h000050, 0);
		issue_request(REQ_UNUSED, 16'hbeef, 1'b1, 24'h000000, 24'hffffff, 0);
		issue_request(REQ_INSERT, 16'h0006, 1'b1, 24'h000800, 24'h000060, 0);
		repeat (9) issue_request(REQ_POP, 16'h0000, 1'b0, 24'h000000, 24'h000000, 0);
		issue_request(REQ_POP, 16'hffff, 1'b1, 24'hffffff, 24'hffffff, 3);
		issue_request(REQ_APPEND, 16'hffff, 1'b1, 24'hffffff, 24'hffffff, 0);
		issue_request(REQ_INSERT, 16'h0000, 1'b0, 24'h000000, 24'h000000, 0);
		issue_request(REQ_POP, 16'h0000, 1'b0, 24'h000000, 24'h000000, 0);
		issue_request(REQ_POP, 16'h0000, 1'b0, 24'h000000, 24'h000000, 0);
		wait_drained();

		ins_pct = 85;
		idle_on = 1'b1;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % PHASE_LEN == 0) begin
				case ($urandom_range(0, 3))
					0: ins_pct = 90;
					1: ins_pct = 12;
					2: ins_pct = 50;
					default: ins_pct = 70;
				endcase
				idle_on = ($urandom_range(0, 2) != 0);
			end
			if (n == RANDOM_WORDS / 2)
				wait_drained();
			pick = $urandom_range(0, 99);
			if (pick < 2)
				req = REQ_UNUSED;
			else if (pick < 2 + ins_pct)
				req = ($urandom_range(0, 3) == 0) ? REQ_APPEND : REQ_INSERT;
			else
				req = REQ_POP;
			if ($urandom_range(0, 1) == 0)
				arr = 24'($urandom_range(0, 15));
			else
				arr = 24'($urandom);
			issue_request(req, 16'($urandom), 1'($urandom), arr, 24'($urandom),
				idle_on ? $urandom_range(0, 9) : 0);
		end
		wait_drained();
		repeat (4) @(negedge clk);

		$display("sent %0d requests (inserts, appends, pops, unused code), checked %0d words",
			words_sent, words_checked);
		$display("peak fill %0d, full rejects %0d, pops on empty %0d",
			peak_fill, full_rejects, empty_pops);
		if (fail_count == 0 && pending == 0) begin
			$display("PASS timestamp_sorted_queue");
		end else begin
			$display("FAIL timestamp_sorted_queue");
		end
		$finish;
	end

endmodule

### sim.f
rtl/tsq_pkg.sv
rtl/tsq_cell.sv
rtl/timestamp_sorted_queue.sv
rtl/tsq_checker.sv
tb/sv/tsq_checker.sv
tb/sv/tb_timestamp_sorted_queue.sv
